### sv/dq_pkg.sv
// shared types and constants for the double-ended queue
// no dependencies

package dq_pkg;

    localparam int DQ_DEPTH   = 16;
    localparam int DQ_VALUE_W = 32;

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_DUMP       = 3'd4
    } dq_action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } dq_status_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_DUMP_START,
        OP_DUMP_NEXT
    } dq_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_WAIT,
        S_OUT,
        S_DUMP_WAIT,
        S_DUMP_OUT
    } dq_state_t;

    typedef struct packed {
        logic [2:0]                    action;
        logic signed [DQ_VALUE_W-1:0]  item_value;
    } dq_in_t;

    typedef struct packed {
        logic signed [DQ_VALUE_W-1:0]  result_value;
        logic                          last_of_run;
        logic [1:0]                    status;
    } dq_out_t;

    typedef struct packed {
        logic       cap;
        dq_op_t     op;
        logic       out_load;
        logic       out_from_ram;
        logic       out_last;
        dq_status_t out_status;
    } dq_cmd_t;

    typedef struct packed {
        logic [2:0] action;
        logic       full;
        logic       empty;
        logic       walk_last;
    } dq_stat_t;

endpackage

### sv/dq_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/dq_dpath.sv
// datapath: entry store, front index, fill count, dump walk counter, result register
// depends on dq_pkg and dq_ram

module dq_dpath #(
    parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  dq_pkg::dq_in_t  req,
    input  dq_pkg::dq_cmd_t cmd,
    output dq_pkg::dq_stat_t stat,
    output dq_pkg::dq_out_t rsp
);

    import dq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = IW + 1;

    logic [IW-1:0]            front_reg, front_next;
    logic [CW-1:0]            fill_reg, fill_next;
    logic [IW-1:0]            walk_reg, walk_next;
    logic [2:0]               act_reg;
    logic [DQ_VALUE_W-1:0]    item_reg;
    logic [DQ_VALUE_W-1:0]    value_reg;
    logic                     last_reg;
    logic [1:0]               status_reg;

    logic                     wr_en;
    logic [IW-1:0]            wr_addr;
    logic                     rd_en;
    logic [IW-1:0]            rd_addr;
    logic [DQ_VALUE_W-1:0]    rd_data;
    logic                     full;
    logic                     empty;
    logic [IW-1:0]            front_dec;

    function automatic logic [IW-1:0] slot_at(input logic [IW-1:0] base,
                                              input logic [SW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + off;
        if (sum >= SW'(DEPTH))
        begin
            sum = sum - SW'(DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    assign full      = (fill_reg == CW'(DEPTH));
    assign empty     = (fill_reg == '0);
    assign front_dec = (front_reg == '0) ? IW'(DEPTH - 1) : front_reg - IW'(1);

    always_comb
    begin
        front_next = front_reg;
        fill_next  = fill_reg;
        walk_next  = walk_reg;
        wr_en      = 1'b0;
        wr_addr    = front_dec;
        rd_en      = 1'b0;
        rd_addr    = front_reg;
        case (cmd.op)
            OP_PUSH_FRONT:
            begin
                wr_en      = 1'b1;
                wr_addr    = front_dec;
                front_next = front_dec;
                fill_next  = fill_reg + CW'(1);
            end
            OP_PUSH_BACK:
            begin
                wr_en     = 1'b1;
                wr_addr   = slot_at(front_reg, SW'(fill_reg));
                fill_next = fill_reg + CW'(1);
            end
            OP_POP_FRONT:
            begin
                rd_en      = 1'b1;
                rd_addr    = front_reg;
                front_next = slot_at(front_reg, SW'(1));
                fill_next  = fill_reg - CW'(1);
            end
            OP_POP_BACK:
            begin
                rd_en     = 1'b1;
                rd_addr   = slot_at(front_reg, SW'(fill_reg) - SW'(1));
                fill_next = fill_reg - CW'(1);
            end
            OP_DUMP_START:
            begin
                rd_en     = 1'b1;
                rd_addr   = front_reg;
                walk_next = '0;
            end
            OP_DUMP_NEXT:
            begin
                rd_en     = 1'b1;
                rd_addr   = slot_at(front_reg, SW'(walk_reg) + SW'(1));
                walk_next = walk_reg + IW'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            fill_reg  <= '0;
            walk_reg  <= '0;
        end
        else
        begin
            front_reg <= front_next;
            fill_reg  <= fill_next;
            walk_reg  <= walk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            act_reg  <= req.action;
            item_reg <= req.item_value;
        end
        if (cmd.out_load)
        begin
            value_reg  <= cmd.out_from_ram ? rd_data : '0;
            last_reg   <= cmd.out_last;
            status_reg <= cmd.out_status;
        end
    end

    dq_ram #(
        .WIDTH (DQ_VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (item_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign stat.action    = act_reg;
    assign stat.full      = full;
    assign stat.empty     = empty;
    assign stat.walk_last = ((SW'(walk_reg) + SW'(1)) == SW'(fill_reg));

    assign rsp.result_value = value_reg;
    assign rsp.last_of_run  = last_reg;
    assign rsp.status       = status_reg;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(DEPTH))
        else $error("fill count beyond depth");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_PUSH_FRONT || cmd.op == OP_PUSH_BACK) |-> !full)
        else $error("store written while full");

    a_read_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_POP_FRONT || cmd.op == OP_POP_BACK || cmd.op == OP_DUMP_START
         || cmd.op == OP_DUMP_NEXT) |-> !empty)
        else $error("store read while empty");
`endif

endmodule

### sv/dq_ctrl.sv
// controller state machine: handshakes, action decode, dump walk sequencing
// depends on dq_pkg

module dq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    input  dq_pkg::dq_stat_t stat,
    output dq_pkg::dq_cmd_t  cmd
);

    import dq_pkg::*;

    dq_state_t state_reg, state_next;
    logic      pending_reg, pending_next;
    logic      req_acc;
    logic      rsp_acc;

    assign req_stall = !(state_reg == S_IDLE || (state_reg == S_OUT && !pending_reg));
    assign rsp_valid = (state_reg inside {S_OUT, S_DUMP_OUT});
    assign req_acc   = req_valid && !req_stall;
    assign rsp_acc   = rsp_valid && !rsp_stall;

    // next state
    always_comb
    begin
        state_next   = state_reg;
        pending_next = pending_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (stat.action)
                    ACT_PUSH_FRONT, ACT_PUSH_BACK:
                        state_next = S_OUT;
                    ACT_POP_FRONT, ACT_POP_BACK:
                        state_next = stat.empty ? S_OUT : S_POP_WAIT;
                    ACT_DUMP:
                        state_next = stat.empty ? S_OUT : S_DUMP_WAIT;
                    default:
                        state_next = S_IDLE;
                endcase
            end
            S_POP_WAIT:
                state_next = S_OUT;
            S_OUT:
            begin
                if (rsp_acc)
                begin
                    state_next   = (pending_reg || req_acc) ? S_EXEC : S_IDLE;
                    pending_next = 1'b0;
                end
                else if (req_acc)
                begin
                    pending_next = 1'b1;
                end
            end
            S_DUMP_WAIT:
                state_next = S_DUMP_OUT;
            S_DUMP_OUT:
            begin
                if (rsp_acc)
                begin
                    state_next = stat.walk_last ? S_IDLE : S_DUMP_WAIT;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd              = '0;
        cmd.op           = OP_NONE;
        cmd.out_status   = ST_OK;
        cmd.cap          = req_acc;
        case (state_reg)
            S_EXEC:
            begin
                case (stat.action)
                    ACT_PUSH_FRONT, ACT_PUSH_BACK:
                    begin
                        cmd.out_load   = 1'b1;
                        cmd.out_last   = 1'b1;
                        if (stat.full)
                        begin
                            cmd.out_status = ST_FULL;
                        end
                        else
                        begin
                            cmd.op = (stat.action == ACT_PUSH_FRONT) ?
                                     OP_PUSH_FRONT : OP_PUSH_BACK;
                        end
                    end
                    ACT_POP_FRONT, ACT_POP_BACK:
                    begin
                        if (stat.empty)
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_last   = 1'b1;
                            cmd.out_status = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.op = (stat.action == ACT_POP_FRONT) ?
                                     OP_POP_FRONT : OP_POP_BACK;
                        end
                    end
                    ACT_DUMP:
                    begin
                        if (stat.empty)
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_last   = 1'b1;
                            cmd.out_status = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.op = OP_DUMP_START;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_POP_WAIT:
            begin
                cmd.out_load     = 1'b1;
                cmd.out_from_ram = 1'b1;
                cmd.out_last     = 1'b1;
            end
            S_DUMP_WAIT:
            begin
                cmd.out_load     = 1'b1;
                cmd.out_from_ram = 1'b1;
                cmd.out_last     = stat.walk_last;
            end
            S_DUMP_OUT:
            begin
                if (rsp_acc && !stat.walk_last)
                begin
                    cmd.op = OP_DUMP_NEXT;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pending_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_acc_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> (state_reg == S_EXEC || pending_reg))
        else $error("accepted item lost");
`endif

endmodule

### sv/double_ended_queue.sv
// A bounded double-ended queue of DEPTH signed 32-bit values held in a circular
// ram. A push, a refused push, or a pop or dump on an empty store loads its one
// result item in the execute state; a pop that removes a value loads it in the
// pop wait state, after the registered store read. A dump gives one result per
// stored value and reads the next only once rsp takes the last. The next item is
// taken while a push or pop result still waits on rsp. Depends on dq_pkg, dq_ctrl, dq_dpath.

module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  dq_pkg::dq_in_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output dq_pkg::dq_out_t rsp
);

    import dq_pkg::*;

    dq_cmd_t  cmd;
    dq_stat_t stat;

    dq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    dq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule

### dv/double_ended_queue_tb.sv
// self-checking testbench for double_ended_queue: directed corner items, then random bursts
// a local deque predictor holds the expected result items, checked in order at rsp
// depends on dq_pkg and double_ended_queue

module double_ended_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dq_pkg::*;

    localparam int         RANDOM_ITEMS     = 340;
    localparam int         STALL_PCT        = 33;
    localparam int         IDLE_LIMIT       = 2000;
    localparam int         CALM_FIRST       = 140;
    localparam int         CALM_LAST        = 230;
    localparam int         REPORT_MAX       = 10;
    localparam logic [2:0] ACT_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] ACT_LAST_UNUSED  = 3'd7;
    localparam logic signed [DQ_VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic signed [DQ_VALUE_W-1:0] VAL_MAX = 32'h7fff_ffff;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_ANY, MIX_DUMP} mix_t;

    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    req_valid = 1'b0;
    logic    req_stall;
    dq_in_t  req       = '0;
    logic    rsp_valid;
    logic    rsp_stall = 1'b0;
    dq_out_t rsp;

    dq_in_t  pending_items[$];
    dq_out_t awaited_rsp[$];

    logic signed [DQ_VALUE_W-1:0] deque_store [DQ_DEPTH];
    int deque_head  = 0;
    int deque_count = 0;

    int issued_cnt  = 0;
    int push_cnt    = 0;
    int pop_cnt     = 0;
    int dump_cnt    = 0;
    int ignored_cnt = 0;
    int full_hits   = 0;
    int empty_hits  = 0;
    int checked_cnt = 0;
    int fault_cnt   = 0;
    int idle_cycles = 0;

    wire no_idle = (issued_cnt >= CALM_FIRST) && (issued_cnt < CALM_LAST);

    double_ended_queue u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #4 clk = ~clk;

    task automatic apply_action(input dq_in_t it);
        dq_out_t r;
        int      i;
        r = '0;
        r.last_of_run = 1'b1;
        r.status = ST_OK;
        case (it.action)
            ACT_PUSH_FRONT, ACT_PUSH_BACK:
            begin
                push_cnt++;
                if (deque_count >= DQ_DEPTH)
                begin
                    r.status = ST_FULL;
                    full_hits++;
                end
                else if (it.action == ACT_PUSH_FRONT)
                begin
                    deque_head = (deque_head + DQ_DEPTH - 1) % DQ_DEPTH;
                    deque_store[deque_head] = it.item_value;
                    deque_count++;
                end
                else
                begin
                    deque_store[(deque_head + deque_count) % DQ_DEPTH] = it.item_value;
                    deque_count++;
                end
                awaited_rsp.push_back(r);
            end
            ACT_POP_FRONT, ACT_POP_BACK:
            begin
                pop_cnt++;
                if (deque_count == 0)
                begin
                    r.status = ST_EMPTY;
                    empty_hits++;
                end
                else if (it.action == ACT_POP_FRONT)
                begin
                    r.result_value = deque_store[deque_head];
                    deque_head = (deque_head + 1) % DQ_DEPTH;
                    deque_count--;
                end
                else
                begin
                    r.result_value = deque_store[(deque_head + deque_count - 1) % DQ_DEPTH];
                    deque_count--;
                end
                awaited_rsp.push_back(r);
            end
            ACT_DUMP:
            begin
                dump_cnt++;
                if (deque_count == 0)
                begin
                    r.status = ST_EMPTY;
                    empty_hits++;
                    awaited_rsp.push_back(r);
                end
                else
                begin
                    for (i = 0; i < deque_count; i++)
                    begin
                        r.result_value = deque_store[(deque_head + i) % DQ_DEPTH];
                        r.last_of_run = (i == deque_count - 1);
                        awaited_rsp.push_back(r);
                    end
                end
            end
            default:
                ignored_cnt++;
        endcase
    endtask

    function automatic logic signed [DQ_VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_action(input mix_t mode);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 3'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_UNUSED));
        case (mode)
            MIX_FILL:
                if (r < 48) return ACT_PUSH_FRONT;
                else if (r < 90) return ACT_PUSH_BACK;
                else if (r < 96) return $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
                else return ACT_DUMP;
            MIX_DRAIN:
                if (r < 45) return ACT_POP_FRONT;
                else if (r < 85) return ACT_POP_BACK;
                else if (r < 93) return $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
                else return ACT_DUMP;
            MIX_DUMP:
                if (r < 40) return ACT_DUMP;
                else return $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_POP_FRONT;
            default:
                if (r < 25) return ACT_PUSH_FRONT;
                else if (r < 50) return ACT_PUSH_BACK;
                else if (r < 70) return ACT_POP_FRONT;
                else if (r < 90) return ACT_POP_BACK;
                else return ACT_DUMP;
        endcase
    endfunction

    task automatic queue_item(input logic [2:0] act, input logic signed [DQ_VALUE_W-1:0] val);
        dq_in_t it;
        it.action = act;
        it.item_value = val;
        pending_items.push_back(it);
    endtask

    // driver: takes items from the pending queue, holds them while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
                apply_action(req);
            if (!req_valid || !req_stall)
            begin
                if (pending_items.size() != 0 &&
                    (no_idle || $urandom_range(0, 99) >= STALL_PCT))
                begin
                    req_valid <= 1'b1;
                    req       <= pending_items.pop_front();
                    issued_cnt++;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compares each result item against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        dq_out_t want;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                checked_cnt++;
                if (awaited_rsp.size() == 0)
                begin
                    fault_cnt++;
                    if (fault_cnt <= REPORT_MAX)
                        $display("unexpected result item: value %0d last %0b status %0d",
                                 $signed(rsp.result_value), rsp.last_of_run, rsp.status);
                end
                else
                begin
                    want = awaited_rsp.pop_front();
                    if (rsp.result_value !== want.result_value ||
                        rsp.last_of_run !== want.last_of_run ||
                        rsp.status !== want.status)
                    begin
                        fault_cnt++;
                        if (fault_cnt <= REPORT_MAX)
                            $display({"mismatch: expected value %0d last %0b status %0d,",
                                      " got value %0d last %0b status %0d"},
                                     $signed(want.result_value), want.last_of_run,
                                     want.status, $signed(rsp.result_value),
                                     rsp.last_of_run, rsp.status);
                    end
                end
            end
            rsp_stall <= no_idle ? 1'b0 : ($urandom_range(0, 99) < STALL_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles, %0d results outstanding",
                         idle_cycles, awaited_rsp.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        int         made;
        int         burst;
        int         burst_no;
        mix_t       mode;
        logic [2:0] act;

        // empty store and unused codes
        queue_item(ACT_POP_FRONT, VAL_MAX);
        queue_item(ACT_POP_BACK, VAL_MIN);
        queue_item(ACT_DUMP, '1);
        queue_item(ACT_FIRST_UNUSED, 32'h1234_5678);
        queue_item(ACT_FIRST_UNUSED + 3'd1, '1);
        queue_item(ACT_LAST_UNUSED, VAL_MIN);
        // extremes through both ends
        queue_item(ACT_PUSH_FRONT, VAL_MIN);
        queue_item(ACT_PUSH_BACK, VAL_MAX);
        queue_item(ACT_PUSH_FRONT, '1);
        queue_item(ACT_PUSH_BACK, '0);
        queue_item(ACT_PUSH_FRONT, 32'h5555_5555);
        queue_item(ACT_PUSH_BACK, 32'haaaa_aaaa);
        queue_item(ACT_DUMP, '0);
        queue_item(ACT_POP_FRONT, '0);
        queue_item(ACT_POP_BACK, '0);
        queue_item(ACT_POP_FRONT, '1);
        queue_item(ACT_POP_BACK, '1);
        queue_item(ACT_POP_FRONT, '0);
        queue_item(ACT_POP_BACK, '0);
        queue_item(ACT_DUMP, '0);

        // random bursts, the first one push-heavy to drive the store towards full
        made = 0;
        burst_no = 0;
        while (made < RANDOM_ITEMS)
        begin
            mode  = (burst_no == 0) ? MIX_FILL : mix_t'($urandom_range(0, 3));
            burst = (burst_no == 0) ? 26 : $urandom_range(8, 28);
            repeat (burst)
            begin
                act = pick_action(mode);
                queue_item(act, rand_value());
                if (act <= ACT_DUMP)
                    made++;
            end
            burst_no++;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || req_valid)
            @(posedge clk);
        while (awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("covered %0d items: %0d pushes (%0d refused as full), %0d pops, %0d dumps",
                 push_cnt + pop_cnt + dump_cnt + ignored_cnt, push_cnt, full_hits,
                 pop_cnt, dump_cnt);
        $display("checked %0d result items, %0d answered empty, %0d ignored, %0d failures",
                 checked_cnt, empty_hits, ignored_cnt, fault_cnt);
        if (fault_cnt == 0 && awaited_rsp.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### double_ended_queue.f
sv/dq_pkg.sv
sv/dq_ram.sv
sv/dq_dpath.sv
sv/dq_ctrl.sv
sv/double_ended_queue.sv
dv/double_ended_queue_tb.sv
